// ===== design/lswc_pkg.sv =====
// shared types, constants and the outcode function of the line segment window clipper
`default_nettype none
package lswc_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIV_STEPS  = 2 * COORD_BITS;
    localparam int CFG_IDX_W  = 2;

    // outcode bits
    localparam logic [3:0] OC_LEFT   = 4'b0001;
    localparam logic [3:0] OC_RIGHT  = 4'b0010;
    localparam logic [3:0] OC_BOTTOM = 4'b0100;
    localparam logic [3:0] OC_TOP    = 4'b1000;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 2'd0,
        CFG_BOTTOM = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_TOP    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] bottom;
        logic signed [COORD_BITS-1:0] right;
        logic signed [COORD_BITS-1:0] top;
    } t_window;

    // segment as it travels between clip moves
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] x2;
        logic signed [COORD_BITS-1:0] y2;
        logic                         done;
        logic                         acc;
    } t_item;

    function automatic logic [3:0] outcode(input logic signed [COORD_BITS-1:0] x,
                                           input logic signed [COORD_BITS-1:0] y,
                                           input t_window w);
        logic [3:0] c;
        c = '0;
        if (x < w.left) begin
            c = c | OC_LEFT;
        end else if (x > w.right) begin
            c = c | OC_RIGHT;
        end
        if (y < w.bottom) begin
            c = c | OC_BOTTOM;
        end else if (y > w.top) begin
            c = c | OC_TOP;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/line_segment_window_clipper.sv =====
// top level of the cohen-sutherland line segment window clipper
//
//   channel  direction  handshake               payload
//   in       request in i_in_valid / o_in_stall start_x, start_y, end_x, end_y
//   out      request out o_out_valid / i_out_stall accepted, clip_start/end x/y
//   cfg      write in   i_cfg_we                i_cfg_idx, i_cfg_data
//
// one request enters every cycle while the output is not stalled; the pipe runs
// through the four clip moves, each holding a one-bit-per-stage restoring
// divider of 2 * COORD_BITS stages
// reset is synchronous and active low; it clears all valid bits and loads the
// window to left 0, bottom 0, right 500, top 500
// a stall on the output freezes the whole pipe, bubbles included
`default_nettype none
module line_segment_window_clipper (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [lswc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [lswc_pkg::COORD_BITS-1:0]       i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire  signed [lswc_pkg::COORD_BITS-1:0] i_start_x,
    input  wire  signed [lswc_pkg::COORD_BITS-1:0] i_start_y,
    input  wire  signed [lswc_pkg::COORD_BITS-1:0] i_end_x,
    input  wire  signed [lswc_pkg::COORD_BITS-1:0] i_end_y,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic                                  o_accepted,
    output logic signed [lswc_pkg::COORD_BITS-1:0] o_clip_start_x,
    output logic signed [lswc_pkg::COORD_BITS-1:0] o_clip_start_y,
    output logic signed [lswc_pkg::COORD_BITS-1:0] o_clip_end_x,
    output logic signed [lswc_pkg::COORD_BITS-1:0] o_clip_end_y
);
    localparam int MOVES = 4;

    // window registers
    lswc_pkg::t_window r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= '0;
            r_win.bottom <= '0;
            r_win.right  <= lswc_pkg::COORD_BITS'(500);
            r_win.top    <= lswc_pkg::COORD_BITS'(500);
        end else if (i_cfg_we) begin
            case (lswc_pkg::t_cfg_idx'(i_cfg_idx))
                lswc_pkg::CFG_LEFT:   r_win.left   <= i_cfg_data;
                lswc_pkg::CFG_BOTTOM: r_win.bottom <= i_cfg_data;
                lswc_pkg::CFG_RIGHT:  r_win.right  <= i_cfg_data;
                lswc_pkg::CFG_TOP:    r_win.top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe advances unless the output register is full and held
    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // chain of four clip moves
    lswc_pkg::t_item item [0:MOVES];
    logic            vld  [0:MOVES];

    always_comb begin
        item[0]      = '0;
        item[0].x1   = i_start_x;
        item[0].y1   = i_start_y;
        item[0].x2   = i_end_x;
        item[0].y2   = i_end_y;
        vld[0]       = i_in_valid;
    end

    for (genvar m = 0; m < MOVES; m++) begin : g_move
        lswc_move u_move (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_win   (r_win),
            .i_valid (vld[m]),
            .i_item  (item[m]),
            .o_valid (vld[m+1]),
            .o_item  (item[m+1])
        );
    end

    // final accept test after the last move, then the output register
    logic [3:0] fc1, fc2;
    logic       n_acc;
    lswc_pkg::t_item r_out;
    logic            r_out_acc;

    always_comb begin
        fc1 = lswc_pkg::outcode(item[MOVES].x1, item[MOVES].y1, r_win);
        fc2 = lswc_pkg::outcode(item[MOVES].x2, item[MOVES].y2, r_win);
        if (item[MOVES].done) begin
            n_acc = item[MOVES].acc;
        end else begin
            // unresolved after four moves: accept only if already inside
            n_acc = (fc1 == 4'd0) && (fc2 == 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= vld[MOVES];
        end
        if (en) begin
            r_out     <= item[MOVES];
            r_out_acc <= n_acc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out_acc;
    assign o_clip_start_x = r_out.x1;
    assign o_clip_start_y = r_out.y1;
    assign o_clip_end_x   = r_out.x2;
    assign o_clip_end_y   = r_out.y2;

    // accepted segments lie inside the window at both ends
    a_acc_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_acc) |->
            (lswc_pkg::outcode(r_out.x1, r_out.y1, r_win) == 4'd0 &&
             lswc_pkg::outcode(r_out.x2, r_out.y2, r_win) == 4'd0))
        else $error("accepted segment has an endpoint outside the window");

    // a rejected segment never has both ends inside
    a_rej_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_acc) |->
            (lswc_pkg::outcode(r_out.x1, r_out.y1, r_win) != 4'd0 ||
             lswc_pkg::outcode(r_out.x2, r_out.y2, r_win) != 4'd0))
        else $error("rejected segment lies wholly inside the window");

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !r_out_valid)
        else $error("output valid just after reset");

    // a held result is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_acc)))
        else $error("held result changed");

endmodule
`default_nettype wire

// ===== design/lswc_move.sv =====
// one clip move: edge choice, multiply, restoring divide, clamp and update
`default_nettype none
module lswc_move (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  lswc_pkg::t_window    i_win,
    input  wire                  i_valid,
    input  lswc_pkg::t_item      i_item,
    output logic                 o_valid,
    output lswc_pkg::t_item      o_item
);
    localparam int W  = lswc_pkg::COORD_BITS;
    localparam int N  = lswc_pkg::DIV_STEPS;
    localparam int SW = 2 * W + 2;

    typedef struct packed {
        lswc_pkg::t_item     item;
        logic                active;    // a move is made on this item
        logic                sel_end;   // move the second endpoint
        logic                horiz;     // top or bottom edge: y goes to the edge
        logic signed [W-1:0] edge_v;
        logic signed [W-1:0] base;
        logic                neg;
        logic                den_zero;
        logic [W-1:0]        mag_a;
        logic [W-1:0]        mag_b;
        logic [W-1:0]        mag_c;
        logic [2*W-1:0]      dq;        // dividend shifting out, quotient shifting in
        logic [W-1:0]        rem;
    } t_pipe;

    function automatic logic [W-1:0] mag(input logic signed [W:0] v);
        logic signed [W:0] n;
        n = -v;
        return (v < 0) ? n[W-1:0] : v[W-1:0];
    endfunction

    function automatic t_pipe div_step(input t_pipe p);
        t_pipe    q;
        logic [W:0] trial;
        q     = p;
        trial = {p.rem, p.dq[2*W-1]};
        q.dq  = {p.dq[2*W-2:0], 1'b0};
        if (trial >= {1'b0, p.mag_c}) begin
            trial   = trial - {1'b0, p.mag_c};
            q.dq[0] = 1'b1;
        end
        q.rem = trial[W-1:0];
        return q;
    endfunction

    // stage a: decide and set up
    t_pipe n_a, r_a;
    logic  r_a_v;
    logic [3:0] c1, c2, co;
    logic signed [W:0] d_x, d_y, n_v, den_v, del_v;

    always_comb begin
        n_a       = '0;
        n_a.item  = i_item;
        c1        = lswc_pkg::outcode(i_item.x1, i_item.y1, i_win);
        c2        = lswc_pkg::outcode(i_item.x2, i_item.y2, i_win);
        co        = (c1 != 4'd0) ? c1 : c2;
        d_x       = (W+1)'(i_item.x2) - (W+1)'(i_item.x1);
        d_y       = (W+1)'(i_item.y2) - (W+1)'(i_item.y1);
        n_v       = '0;
        den_v     = d_y;
        del_v     = d_x;
        n_a.base  = i_item.x1;
        n_a.horiz = 1'b1;
        if ((co & lswc_pkg::OC_TOP) != 4'd0) begin
            n_a.edge_v = i_win.top;
            n_v        = (W+1)'(i_win.top) - (W+1)'(i_item.y1);
        end else if ((co & lswc_pkg::OC_BOTTOM) != 4'd0) begin
            n_a.edge_v = i_win.bottom;
            n_v        = (W+1)'(i_win.bottom) - (W+1)'(i_item.y1);
        end else begin
            n_a.horiz  = 1'b0;
            n_a.base   = i_item.y1;
            den_v      = d_x;
            del_v      = d_y;
            if ((co & lswc_pkg::OC_RIGHT) != 4'd0) begin
                n_a.edge_v = i_win.right;
                n_v        = (W+1)'(i_win.right) - (W+1)'(i_item.x1);
            end else begin
                n_a.edge_v = i_win.left;
                n_v        = (W+1)'(i_win.left) - (W+1)'(i_item.x1);
            end
        end
        n_a.sel_end  = (c1 == 4'd0);
        n_a.mag_a    = mag(del_v);
        n_a.mag_b    = mag(n_v);
        n_a.mag_c    = mag(den_v);
        n_a.neg      = del_v[W] ^ n_v[W] ^ den_v[W];
        n_a.den_zero = (den_v == '0);
        if (!i_item.done) begin
            if (c1 == 4'd0 && c2 == 4'd0) begin
                n_a.item.done = 1'b1;
                n_a.item.acc  = 1'b1;
            end else if ((c1 & c2) != 4'd0) begin
                n_a.item.done = 1'b1;
                n_a.item.acc  = 1'b0;
            end else begin
                n_a.active = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
        if (i_en) begin
            r_a <= n_a;
        end
    end

    // stage b: product into the dividend, then one quotient bit per stage
    t_pipe r_d   [0:N];
    logic  r_d_v [0:N];
    t_pipe n_d0;

    always_comb begin
        n_d0     = r_a;
        n_d0.dq  = (2*W)'(r_a.mag_a) * (2*W)'(r_a.mag_b);
        n_d0.rem = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v[0] <= 1'b0;
        end else if (i_en) begin
            r_d_v[0] <= r_a_v;
        end
        if (i_en) begin
            r_d[0] <= n_d0;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[k] <= 1'b0;
            end else if (i_en) begin
                r_d_v[k] <= r_d_v[k-1];
            end
            if (i_en) begin
                r_d[k] <= div_step(r_d[k-1]);
            end
        end
    end

    // stage e: signed sum, clamp and endpoint update
    lswc_pkg::t_item n_e, r_e;
    logic            r_e_v;
    logic signed [SW-1:0] qs, s;
    logic signed [W-1:0]  sat;
    t_pipe p;

    always_comb begin
        p  = r_d[N];
        qs = signed'({2'b00, p.dq});
        if (p.neg) begin
            qs = -qs;
        end
        if (p.den_zero) begin
            qs = '0;
        end
        s = SW'(p.base) + qs;
        if (s > SW'(lswc_pkg::COORD_MAX)) begin
            sat = lswc_pkg::COORD_MAX;
        end else if (s < SW'(lswc_pkg::COORD_MIN)) begin
            sat = lswc_pkg::COORD_MIN;
        end else begin
            sat = s[W-1:0];
        end
        n_e = p.item;
        if (p.active) begin
            if (!p.sel_end) begin
                n_e.x1 = p.horiz ? sat : p.edge_v;
                n_e.y1 = p.horiz ? p.edge_v : sat;
            end else begin
                n_e.x2 = p.horiz ? sat : p.edge_v;
                n_e.y2 = p.horiz ? p.edge_v : sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (i_en) begin
            r_e_v <= r_d_v[N];
        end
        if (i_en) begin
            r_e <= n_e;
        end
    end

    assign o_valid = r_e_v;
    assign o_item  = r_e;

endmodule
`default_nettype wire

// ===== bench/line_segment_window_clipper_tb.sv =====
// self-checking bench for the line segment window clipper: directed and random segments
`timescale 1ns / 100ps
`default_nettype none
module line_segment_window_clipper_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 160;   // a little over the depth of the pipe
    localparam int CB             = lswc_pkg::COORD_BITS;

    typedef struct {
        logic signed [CB-1:0] sx, sy, ex, ey;
    } t_segment;

    typedef struct {
        logic                 acc;
        logic signed [CB-1:0] sx, sy, ex, ey;
    } t_clip_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [lswc_pkg::CFG_IDX_W-1:0]     cfg_idx = '0;
    logic [CB-1:0]                      cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic signed [CB-1:0]               seg_sx = '0, seg_sy = '0, seg_ex = '0, seg_ey = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               res_acc;
    logic signed [CB-1:0]               res_sx, res_sy, res_ex, res_ey;

    // window as the bench believes it, indexed by register
    longint       win [4];
    t_segment     segments_pending[$];
    t_clip_result clips_due[$];
    int           fails = 0;
    int           idle_cycles = 0;

    line_segment_window_clipper DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_start_x     (seg_sx),
        .i_start_y     (seg_sy),
        .i_end_x       (seg_ex),
        .i_end_y       (seg_ey),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_accepted    (res_acc),
        .o_clip_start_x(res_sx),
        .o_clip_start_y(res_sy),
        .o_clip_end_x  (res_ex),
        .o_clip_end_y  (res_ey)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic longint sat_coord(longint v);
        if (v > longint'(lswc_pkg::COORD_MAX)) return longint'(lswc_pkg::COORD_MAX);
        if (v < longint'(lswc_pkg::COORD_MIN)) return longint'(lswc_pkg::COORD_MIN);
        return v;
    endfunction

    function automatic logic [3:0] region_code(longint x, longint y);
        logic [3:0] c;
        c = '0;
        if (x < win[lswc_pkg::CFG_LEFT]) c |= lswc_pkg::OC_LEFT;
        else if (x > win[lswc_pkg::CFG_RIGHT]) c |= lswc_pkg::OC_RIGHT;
        if (y < win[lswc_pkg::CFG_BOTTOM]) c |= lswc_pkg::OC_BOTTOM;
        else if (y > win[lswc_pkg::CFG_TOP]) c |= lswc_pkg::OC_TOP;
        return c;
    endfunction

    // base + delta * num / den, truncated toward zero, saturated; zero den keeps base
    function automatic longint edge_cross(longint base, longint delta, longint num, longint den);
        longint q;
        bit     neg;
        if (den == 0) return sat_coord(base);
        neg = (delta < 0) ^ (num < 0) ^ (den < 0);
        q = ((delta < 0 ? -delta : delta) * (num < 0 ? -num : num)) / (den < 0 ? -den : den);
        return sat_coord(neg ? base - q : base + q);
    endfunction

    function automatic t_clip_result clip_segment(t_segment s);
        t_clip_result r;
        longint       x1, y1, x2, y2, nx, ny;
        logic [3:0]   c1, c2, co;
        x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
        c1 = region_code(x1, y1);
        c2 = region_code(x2, y2);
        r.acc = 1'b0;
        for (int mv = 0; mv <= 4; mv++) begin
            if (c1 == 0 && c2 == 0) begin
                r.acc = 1'b1;
                break;
            end
            // trivial reject, or still unresolved after four moves
            if ((c1 & c2) != 0 || mv == 4) break;
            co = (c1 != 0) ? c1 : c2;
            if (co & lswc_pkg::OC_TOP) begin
                ny = win[lswc_pkg::CFG_TOP];
                nx = edge_cross(x1, x2 - x1, win[lswc_pkg::CFG_TOP] - y1, y2 - y1);
            end else if (co & lswc_pkg::OC_BOTTOM) begin
                ny = win[lswc_pkg::CFG_BOTTOM];
                nx = edge_cross(x1, x2 - x1, win[lswc_pkg::CFG_BOTTOM] - y1, y2 - y1);
            end else if (co & lswc_pkg::OC_RIGHT) begin
                nx = win[lswc_pkg::CFG_RIGHT];
                ny = edge_cross(y1, y2 - y1, win[lswc_pkg::CFG_RIGHT] - x1, x2 - x1);
            end else begin
                nx = win[lswc_pkg::CFG_LEFT];
                ny = edge_cross(y1, y2 - y1, win[lswc_pkg::CFG_LEFT] - x1, x2 - x1);
            end
            if (c1 != 0) begin
                x1 = nx; y1 = ny;
                c1 = region_code(x1, y1);
            end else begin
                x2 = nx; y2 = ny;
                c2 = region_code(x2, y2);
            end
        end
        r.sx = x1[CB-1:0];
        r.sy = y1[CB-1:0];
        r.ex = x2[CB-1:0];
        r.ey = y2[CB-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // request driver: bursts of random length, random gaps between them
    // ---------------------------------------------------------------

    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_segment s;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                s.sx = seg_sx; s.sy = seg_sy; s.ex = seg_ex; s.ey = seg_ey;
                clips_due.push_back(clip_segment(s));
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (segments_pending.size() > 0) begin
                s = segments_pending.pop_front();
                seg_sx   <= s.sx;
                seg_sy   <= s.sy;
                seg_ex   <= s.ex;
                seg_ey   <= s.ey;
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor and output stall pattern
    // ---------------------------------------------------------------

    int stall_level = 0;
    int stall_tick  = 0;

    always @(posedge i_clk) begin
        t_clip_result due;
        if (i_rst_n && out_valid && !out_stall) begin
            if (clips_due.size() == 0) begin
                $error("result with no request outstanding");
                fails++;
            end else begin
                due = clips_due.pop_front();
                if (res_acc !== due.acc) begin
                    $error("accepted: expected %0d, got %0d", due.acc, res_acc);
                    fails++;
                end
                if (res_sx !== due.sx) begin
                    $error("clip_start_x: expected %0d, got %0d", due.sx, res_sx);
                    fails++;
                end
                if (res_sy !== due.sy) begin
                    $error("clip_start_y: expected %0d, got %0d", due.sy, res_sy);
                    fails++;
                end
                if (res_ex !== due.ex) begin
                    $error("clip_end_x: expected %0d, got %0d", due.ex, res_ex);
                    fails++;
                end
                if (res_ey !== due.ey) begin
                    $error("clip_end_y: expected %0d, got %0d", due.ey, res_ey);
                    fails++;
                end
            end
        end
        // stall density is redrawn periodically, often to none at all
        stall_tick++;
        if (stall_tick % 300 == 0) begin
            stall_level = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        out_stall <= ($urandom_range(0, 7) < stall_level);
    end

    // watchdog: only counts while work is outstanding
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (segments_pending.size() == 0 && clips_due.size() == 0 && !in_valid)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL line_segment_window_clipper");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic set_window(longint l, longint b, longint r, longint t);
        longint v [4];
        v[lswc_pkg::CFG_LEFT] = l;  v[lswc_pkg::CFG_BOTTOM] = b;
        v[lswc_pkg::CFG_RIGHT] = r; v[lswc_pkg::CFG_TOP] = t;
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= i[lswc_pkg::CFG_IDX_W-1:0];
            cfg_data <= v[i][CB-1:0];
            // the register keeps only the low bits, read back as signed
            win[i] = longint'($signed(v[i][CB-1:0]));
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait for the pipe to empty, then let the tail drain
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (segments_pending.size() > 0 || in_valid || clips_due.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_segment(longint sx, longint sy, longint ex, longint ey);
        t_segment s;
        s.sx = sx[CB-1:0]; s.sy = sy[CB-1:0];
        s.ex = ex[CB-1:0]; s.ey = ey[CB-1:0];
        segments_pending.push_back(s);
    endtask

    // mostly near the window span, sometimes anywhere or at the extremes
    function automatic longint pick_coord(longint lo, longint hi);
        longint span;
        span = (hi > lo ? hi - lo : lo - hi) + 8;
        case ($urandom_range(0, 9))
            0:       return longint'($signed(16'($urandom)));
            1:       return $urandom_range(0, 1) ? longint'(lswc_pkg::COORD_MAX)
                                                 : longint'(lswc_pkg::COORD_MIN);
            2:       return sat_coord(lo + $urandom_range(0, 4) - 2);
            3:       return sat_coord(hi + $urandom_range(0, 4) - 2);
            default: return sat_coord(lo - span / 2 + longint'($urandom_range(0, 2 * span)));
        endcase
    endfunction

    task automatic add_random(int count);
        repeat (count) begin
            add_segment(pick_coord(win[lswc_pkg::CFG_LEFT], win[lswc_pkg::CFG_RIGHT]),
                        pick_coord(win[lswc_pkg::CFG_BOTTOM], win[lswc_pkg::CFG_TOP]),
                        pick_coord(win[lswc_pkg::CFG_LEFT], win[lswc_pkg::CFG_RIGHT]),
                        pick_coord(win[lswc_pkg::CFG_BOTTOM], win[lswc_pkg::CFG_TOP]));
        end
    endtask

    function automatic longint any_coord();
        return longint'($signed(16'($urandom)));
    endfunction

    initial begin
        longint a, b;
        // reset values of the window
        win[lswc_pkg::CFG_LEFT]  = 0; win[lswc_pkg::CFG_BOTTOM] = 0;
        win[lswc_pkg::CFG_RIGHT] = 500; win[lswc_pkg::CFG_TOP] = 500;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, on the reset window
        add_segment(10, 10, 400, 450);              // fully inside
        add_segment(0, 0, 500, 500);                // on the corners
        add_segment(-100, -100, -10, 600);          // both left: trivial reject
        add_segment(-100, 250, 600, 250);           // horizontal, left and right
        add_segment(250, -100, 250, 600);           // vertical, bottom and top
        add_segment(-32768, -32768, 32767, 32767);  // extreme diagonal
        add_segment(32767, -32768, -32768, 32767);  // extreme anti-diagonal
        add_segment(-32768, -32768, -32768, -32768);// zero length outside
        add_segment(32767, 32767, 32767, 32767);
        add_segment(250, 250, 250, 250);            // zero length inside
        add_segment(-50, 450, 100, 560);            // cuts the top left corner region
        add_segment(-300, 600, 600, -300);          // enters the window, needs several moves
        add_segment(450, -60, 560, 100);
        add_segment(600, 250, 250, 250);            // start point moves only
        wait_idle();
        add_random(250);
        wait_idle();

        // full coordinate range as window
        set_window(lswc_pkg::COORD_MIN, lswc_pkg::COORD_MIN,
                   lswc_pkg::COORD_MAX, lswc_pkg::COORD_MAX);
        add_segment(-32768, -32768, 32767, 32767);
        add_segment(-32768, 32767, 32767, -32768);
        add_random(150);
        wait_idle();

        // single point window at the extremes
        set_window(lswc_pkg::COORD_MAX, lswc_pkg::COORD_MIN,
                   lswc_pkg::COORD_MAX, lswc_pkg::COORD_MIN);
        add_segment(-32768, 32767, 32767, -32768);
        add_random(150);
        wait_idle();

        // inverted window: odd outcodes, zero denominators, saturation
        set_window(300, 200, -300, -200);
        add_segment(-32768, -32768, 32767, 32767);
        add_segment(0, 0, 0, 0);
        add_random(300);
        wait_idle();

        // a run of random windows, ordered or not
        repeat (6) begin
            a = any_coord(); b = any_coord();
            if ($urandom_range(0, 3) != 0) begin
                set_window(a < b ? a : b, a < b ? a : b, a < b ? b : a,
                           (a < b ? b : a) - $urandom_range(0, 100));
            end else begin
                set_window(any_coord(), any_coord(), any_coord(), any_coord());
            end
            add_random(170);
            wait_idle();
        end

        if (fails == 0) begin
            $display("PASS line_segment_window_clipper");
        end else begin
            $display("FAIL line_segment_window_clipper");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/lswc_pkg.sv
design/lswc_move.sv
design/line_segment_window_clipper.sv
bench/line_segment_window_clipper_tb.sv
